[hdl/harmonic_oscillator_integrator_defines.svh]
// Assertion macros shared by the oscillator integrator RTL.
// No dependencies; define SYNTH to compile the checks away.
`ifndef HARMONIC_OSCILLATOR_INTEGRATOR_DEFINES_SVH
`define HARMONIC_OSCILLATOR_INTEGRATOR_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define HOI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hoi check failed (same cycle)");
// next-cycle implication
`define HOI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hoi check failed (next cycle)");
`else
`define HOI_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define HOI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/hoi_pkg.sv]
// Shared widths, register map, reset values and saturation helpers
// for the oscillator integrator. No dependencies.
package hoi_pkg;

    localparam int POS_W      = 32;   // Q4.28 position / velocity
    localparam int TIME_W     = 40;   // Q16.24 time
    localparam int DT_W       = 24;   // Q0.24 step
    localparam int W2_W       = 32;   // Q8.24 omega squared
    localparam int SLOPE_W    = 40;   // velocity slope, Q.28
    localparam int FRAC_SHIFT = 24;
    localparam int WIDE_W     = 42;   // pre-saturation sums

    localparam int MCAND_W  = SLOPE_W;
    localparam int MPLIER_W = W2_W;
    localparam int PROD_W   = MCAND_W + MPLIER_W;
    localparam int CNT_W    = $clog2(MPLIER_W + 1);

    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = TIME_W + 2 * POS_W;
    localparam int RESTART_BIT = 0;

    localparam int APB_AW    = 6;
    localparam int APB_DW    = 64;
    localparam int ADDR_LSB  = 3;
    localparam int REG_IDX_W = APB_AW - ADDR_LSB;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_METHOD = 3'd0,
        REG_STEP   = 3'd1,
        REG_OMEGA2 = 3'd2,
        REG_T0     = 3'd3,
        REG_X0     = 3'd4,
        REG_V0     = 3'd5
    } t_reg_idx;

    localparam logic              RST_METHOD = 1'b1;
    localparam logic [DT_W-1:0]   RST_STEP   = 24'd167772;
    localparam logic [W2_W-1:0]   RST_OMEGA2 = 32'd16777216;
    localparam logic [TIME_W-1:0] RST_T0     = '0;
    localparam logic [POS_W-1:0]  RST_X0     = 32'h1000_0000;
    localparam logic [POS_W-1:0]  RST_V0     = '0;

    typedef struct packed {
        logic start;
        logic narrow;   // multiplier is DT_W bits instead of MPLIER_W
    } t_mul_ctl;

    function automatic logic is_clip(input logic signed [WIDE_W-1:0] val);
        return !((&val[WIDE_W-1:POS_W-1]) || !(|val[WIDE_W-1:POS_W-1]));
    endfunction

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [WIDE_W-1:0] val);
        if (is_clip(val)) begin
            return val[WIDE_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        return val[POS_W-1:0];
    endfunction

endpackage

[hdl/hoi_serial_mul.sv]
// Bit-serial shift-add multiplier: signed multiplicand times unsigned
// multiplier, one multiplier bit per cycle. Depends on hoi_pkg.
module hoi_serial_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  hoi_pkg::t_mul_ctl                    i_ctl,
    input  logic signed [hoi_pkg::MCAND_W-1:0]   i_mcand,
    input  logic        [hoi_pkg::MPLIER_W-1:0]  i_mplier,
    output logic                                 o_done,
    output logic signed [hoi_pkg::PROD_W-1:0]    o_product
);
    import hoi_pkg::*;

    localparam int LSB_DROP = MPLIER_W - DT_W;
    localparam int EXT_W    = PROD_W - (MCAND_W + 1) - DT_W;

    logic signed [MCAND_W:0]   r_hi;
    logic        [MCAND_W:0]   n_sum;
    logic        [MPLIER_W-1:0] r_lo;
    logic        [MPLIER_W-1:0] r_b;
    logic signed [MCAND_W-1:0] r_a;
    logic        [CNT_W-1:0]   r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic                      r_narrow;

    // high half accumulates, then the pair shifts right one place
    assign n_sum = r_hi + (r_b[0] ? {r_a[MCAND_W-1], r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.narrow ? CNT_W'(DT_W) : CNT_W'(MPLIER_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_hi     <= '0;
            r_lo     <= '0;
            r_a      <= i_mcand;
            r_b      <= i_mplier;
            r_narrow <= i_ctl.narrow;
        end else if (r_busy) begin
            r_hi <= {n_sum[MCAND_W], n_sum[MCAND_W:1]};
            r_lo <= {n_sum[0], r_lo[MPLIER_W-1:1]};
            r_b  <= {1'b0, r_b[MPLIER_W-1:1]};
        end
    end

    // short runs leave the product LSB_DROP places high in the pair
    assign o_product = r_narrow ?
        {{EXT_W{r_hi[MCAND_W]}}, r_hi, r_lo[MPLIER_W-1:LSB_DROP]} :
        {r_hi[MCAND_W-1:0], r_lo};
    assign o_done = r_done;

endmodule

[hdl/harmonic_oscillator_integrator.sv]
// Top level of the fixed-point harmonic oscillator integrator (Euler / Heun).
// Depends on hoi_pkg, hoi_serial_mul and harmonic_oscillator_integrator_defines.svh.
//
//  port group  dir  handshake                  beat contents (low bit first)
//  s_t*        in   s_tvalid / s_tready        tdata: restart
//  m_t*        out  m_tvalid / m_tready        tdata: time_now, position, velocity;
//                                              tuser: saturated
//  apb         in   psel/penable/pwrite/pready 6 regs at byte address 8*i, 64-bit data
//
// One beat in, one beat out. All products go through a single bit-serial
// multiplier, one multiplier bit per cycle; w2 products use the full multiplier width, dt products the step width.
// A new beat is taken once the previous step has finished, even while its result
// still waits in the output register; a stalled output holds the next step at its end.
// Reset is synchronous, active low, and loads register defaults and initial state.
`include "harmonic_oscillator_integrator_defines.svh"

module harmonic_oscillator_integrator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [hoi_pkg::S_TDATA_W-1:0]      s_tdata,   // [0] restart
    // output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [hoi_pkg::M_TDATA_W-1:0]      m_tdata,   // time_now, position, velocity
    output logic                               m_tuser,   // saturated
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hoi_pkg::APB_AW-1:0]         paddr,
    input  logic [hoi_pkg::APB_DW-1:0]         pwdata,
    output logic [hoi_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);
    import hoi_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_K1   = 9'b000000010,   // w2 * x
        S_DV   = 9'b000000100,   // dt * v
        S_DK1  = 9'b000001000,   // dt * k1
        S_PRED = 9'b000010000,   // Heun predictor
        S_K2   = 9'b000100000,   // w2 * xp
        S_DVP  = 9'b001000000,   // dt * vp, summed into dt * v
        S_DK2  = 9'b010000000,   // dt * k2, summed into dt * k1
        S_FIN  = 9'b100000000    // update state, load output
    } t_state;

    localparam int PA_W  = POS_W + DT_W + 1;      // dt*v (+ dt*vp)
    localparam int PB_W  = SLOPE_W + DT_W + 1;    // dt*k1 (+ dt*k2)
    localparam int XE_W  = WIDE_W - POS_W;
    localparam int PAH_W = PA_W - FRAC_SHIFT;
    localparam int PBH_W = PB_W - FRAC_SHIFT;

    // configuration registers
    logic                     r_method;
    logic [DT_W-1:0]          r_dt;
    logic [W2_W-1:0]          r_w2;
    logic [TIME_W-1:0]        r_t0;
    logic [POS_W-1:0]         r_x0;
    logic [POS_W-1:0]         r_v0;

    // oscillator state and intermediates
    logic signed [POS_W-1:0]   r_x;
    logic signed [POS_W-1:0]   r_v;
    logic        [TIME_W-1:0]  r_t;
    logic signed [POS_W-1:0]   r_xp;
    logic signed [POS_W-1:0]   r_vp;
    logic signed [SLOPE_W-1:0] r_k;
    logic signed [PA_W-1:0]    r_pa;
    logic signed [PB_W-1:0]    r_pb;

    t_state r_state;
    t_state n_state;
    logic   r_wait;

    // output register
    logic                r_ovalid;
    logic                r_osat;
    logic [TIME_W-1:0]   r_otime;
    logic [POS_W-1:0]    r_opos;
    logic [POS_W-1:0]    r_ovel;

    logic                      accept;
    logic                      cfg_wr;
    logic                      mul_state;
    logic                      mul_done;
    logic                      out_free;
    logic                      fin_go;
    t_mul_ctl                  mul_ctl;
    logic signed [MCAND_W-1:0] mul_a;
    logic        [MPLIER_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_prod;
    logic signed [SLOPE_W-1:0] prod_slope;
    logic signed [WIDE_W-1:0]  x_ext;
    logic signed [WIDE_W-1:0]  v_ext;
    logic signed [WIDE_W-1:0]  pred_x;
    logic signed [WIDE_W-1:0]  pred_v;
    logic signed [WIDE_W-1:0]  fin_x;
    logic signed [WIDE_W-1:0]  fin_v;
    logic                      fin_clip;

    assign s_tready = (r_state == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !r_ovalid || m_tready;
    assign fin_go   = (r_state == S_FIN) && out_free;

    assign mul_state = (r_state == S_K1) || (r_state == S_DV) || (r_state == S_DK1) ||
                       (r_state == S_K2) || (r_state == S_DVP) || (r_state == S_DK2);
    assign mul_ctl.start  = mul_state && !r_wait;
    assign mul_ctl.narrow = !((r_state == S_K1) || (r_state == S_K2));

    // operand select for the shared multiplier
    always_comb begin
        mul_a = {{(MCAND_W-POS_W){r_x[POS_W-1]}}, r_x};
        mul_b = r_w2;
        unique case (r_state) inside
            S_K1:  begin
                mul_a = {{(MCAND_W-POS_W){r_x[POS_W-1]}}, r_x};
                mul_b = r_w2;
            end
            S_DV:  begin
                mul_a = {{(MCAND_W-POS_W){r_v[POS_W-1]}}, r_v};
                mul_b = {{(MPLIER_W-DT_W){1'b0}}, r_dt};
            end
            S_K2:  begin
                mul_a = {{(MCAND_W-POS_W){r_xp[POS_W-1]}}, r_xp};
                mul_b = r_w2;
            end
            S_DVP: begin
                mul_a = {{(MCAND_W-POS_W){r_vp[POS_W-1]}}, r_vp};
                mul_b = {{(MPLIER_W-DT_W){1'b0}}, r_dt};
            end
            S_DK1, S_DK2: begin
                mul_a = r_k;
                mul_b = {{(MPLIER_W-DT_W){1'b0}}, r_dt};
            end
            default: begin
                mul_a = {{(MCAND_W-POS_W){r_x[POS_W-1]}}, r_x};
                mul_b = r_w2;
            end
        endcase
    end

    hoi_serial_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mul_ctl),
        .i_mcand   (mul_a),
        .i_mplier  (mul_b),
        .o_done    (mul_done),
        .o_product (mul_prod)
    );

    // k = -floor(w2 * x / 2^24); the floor is the slice itself
    assign prod_slope = -$signed(mul_prod[FRAC_SHIFT+SLOPE_W-1:FRAC_SHIFT]);

    assign x_ext  = {{XE_W{r_x[POS_W-1]}}, r_x};
    assign v_ext  = {{XE_W{r_v[POS_W-1]}}, r_v};
    // Euler increment: floor(p / 2^24)
    assign pred_x = x_ext + {{(WIDE_W-PAH_W){r_pa[PA_W-1]}}, r_pa[PA_W-1:FRAC_SHIFT]};
    assign pred_v = v_ext + {{(WIDE_W-PBH_W){r_pb[PB_W-1]}}, r_pb[PB_W-1:FRAC_SHIFT]};
    // Heun increment: floor((p1 + p2) / 2^25); the sums sit in r_pa / r_pb
    assign fin_x = r_method ?
        x_ext + {{(WIDE_W-PAH_W+1){r_pa[PA_W-1]}}, r_pa[PA_W-1:FRAC_SHIFT+1]} : pred_x;
    assign fin_v = r_method ?
        v_ext + {{(WIDE_W-PBH_W+1){r_pb[PB_W-1]}}, r_pb[PB_W-1:FRAC_SHIFT+1]} : pred_v;
    assign fin_clip = is_clip(fin_x) || is_clip(fin_v);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_K1;
            S_K1:   if (r_wait && mul_done) n_state = S_DV;
            S_DV:   if (r_wait && mul_done) n_state = S_DK1;
            S_DK1:  if (r_wait && mul_done) n_state = r_method ? S_PRED : S_FIN;
            S_PRED: n_state = S_K2;
            S_K2:   if (r_wait && mul_done) n_state = S_DVP;
            S_DVP:  if (r_wait && mul_done) n_state = S_DK2;
            S_DK2:  if (r_wait && mul_done) n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control, configuration and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= 1'b0;
            r_ovalid <= 1'b0;
            r_method <= RST_METHOD;
            r_dt     <= RST_STEP;
            r_w2     <= RST_OMEGA2;
            r_t0     <= RST_T0;
            r_x0     <= RST_X0;
            r_v0     <= RST_V0;
            r_x      <= RST_X0;
            r_v      <= RST_V0;
            r_t      <= RST_T0;
        end else begin
            r_state <= n_state;

            if (mul_ctl.start) begin
                r_wait <= 1'b1;
            end else if (mul_done) begin
                r_wait <= 1'b0;
            end

            if (fin_go) begin
                r_ovalid <= 1'b1;
            end else if (m_tready) begin
                r_ovalid <= 1'b0;
            end

            if (cfg_wr) begin
                unique case (paddr[APB_AW-1:ADDR_LSB])
                    REG_METHOD: r_method <= pwdata[0];
                    REG_STEP:   r_dt     <= pwdata[DT_W-1:0];
                    REG_OMEGA2: r_w2     <= pwdata[W2_W-1:0];
                    REG_T0:     r_t0     <= pwdata[TIME_W-1:0];
                    REG_X0:     r_x0     <= pwdata[POS_W-1:0];
                    REG_V0:     r_v0     <= pwdata[POS_W-1:0];
                    default: ;
                endcase
            end

            if (accept && s_tdata[RESTART_BIT]) begin
                r_x <= r_x0;
                r_v <= r_v0;
                r_t <= r_t0;
            end else if (fin_go) begin
                r_x <= sat32(fin_x);
                r_v <= sat32(fin_v);
                r_t <= r_t + {{(TIME_W-DT_W){1'b0}}, r_dt};   // wraps mod 2^40
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_wait && mul_done) begin
            unique case (r_state) inside
                S_K1, S_K2: r_k  <= prod_slope;
                S_DV:       r_pa <= mul_prod[PA_W-1:0];
                S_DK1:      r_pb <= mul_prod[PB_W-1:0];
                S_DVP:      r_pa <= r_pa + mul_prod[PA_W-1:0];
                S_DK2:      r_pb <= r_pb + mul_prod[PB_W-1:0];
                default: ;
            endcase
        end
        // predictor clipping is not reported
        if (r_state == S_PRED) begin
            r_xp <= sat32(pred_x);
            r_vp <= sat32(pred_v);
        end
        if (fin_go) begin
            r_otime <= r_t;
            r_opos  <= sat32(fin_x);
            r_ovel  <= sat32(fin_v);
            r_osat  <= fin_clip;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[APB_AW-1:ADDR_LSB])
            REG_METHOD: prdata = {{(APB_DW-1){1'b0}}, r_method};
            REG_STEP:   prdata = {{(APB_DW-DT_W){1'b0}}, r_dt};
            REG_OMEGA2: prdata = {{(APB_DW-W2_W){1'b0}}, r_w2};
            REG_T0:     prdata = {{(APB_DW-TIME_W){1'b0}}, r_t0};
            REG_X0:     prdata = {{(APB_DW-POS_W){1'b0}}, r_x0};
            REG_V0:     prdata = {{(APB_DW-POS_W){1'b0}}, r_v0};
            default:    prdata = '0;
        endcase
    end

    assign m_tvalid = r_ovalid;
    assign m_tdata  = {r_ovel, r_opos, r_otime};
    assign m_tuser  = r_osat;

    `HOI_ASSERT_SAME(a_out_from_fin, i_clk, i_rst_n, $rose(m_tvalid), $past(r_state == S_FIN))
    `HOI_ASSERT_SAME(a_done_expected, i_clk, i_rst_n, mul_done, r_wait && mul_state)
    `HOI_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, s_tvalid && s_tready, r_state == S_K1)
    `HOI_ASSERT_NEXT(a_fin_holds, i_clk, i_rst_n, (r_state == S_FIN) && r_ovalid && !m_tready, (r_state == S_FIN) && m_tvalid)

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for harmonic_oscillator_integrator: Euler and Heun steps.
// Uses hoi_pkg for widths and the register map; predicts every output beat itself.
module tb;
    import hoi_pkg::*;

    localparam int ACC_W       = 80;     // wide enough for every exact product and sum
    localparam int MAX_GAP     = 11;
    localparam int WDOG_LIMIT  = 2000;   // idle cycles
    localparam int SETTLE_CYC  = 200;
    localparam int RAND_PHASES = 8;
    localparam int RAND_BEATS  = 92;
    localparam int MAX_PRINTS  = 100;

    localparam logic METHOD_EULER = 1'b0;
    localparam logic METHOD_HEUN  = 1'b1;

    typedef logic signed [ACC_W-1:0] t_acc;

    // one output beat as the stepper should produce it
    typedef struct packed {
        logic [TIME_W-1:0] t_now;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  vel;
        logic              sat;
    } t_osc_beat;

    // ---------------------------------------------------------------- DUT ports
    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;      // [0] restart
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;            // time_now, position, velocity
    logic                 m_tuser;            // saturated
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    harmonic_oscillator_integrator u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------- register shadow and oscillator state
    logic                     cfg_method = RST_METHOD;
    logic [DT_W-1:0]          cfg_dt     = RST_STEP;
    logic [W2_W-1:0]          cfg_w2     = RST_OMEGA2;
    logic [TIME_W-1:0]        cfg_t0     = RST_T0;
    logic [POS_W-1:0]         cfg_x0     = RST_X0;
    logic [POS_W-1:0]         cfg_v0     = RST_V0;

    // after reset the state holds the reset values of the initial-condition registers
    logic signed [POS_W-1:0]  osc_pos  = RST_X0;
    logic signed [POS_W-1:0]  osc_vel  = RST_V0;
    logic [TIME_W-1:0]        osc_time = RST_T0;

    logic          tick_q[$];            // restart flags waiting to be sent
    t_osc_beat     step_results_q[$];    // predicted beats, oldest first
    logic          src_no_idle = 1'b0;
    logic          snk_no_idle = 1'b0;
    int unsigned   src_gap = 0;
    int unsigned   snk_gap = 0;
    int unsigned   ticks_queued = 0;
    int unsigned   ticks_sent = 0;
    int unsigned   results_checked = 0;
    int unsigned   sat_seen = 0;
    int unsigned   mismatches = 0;
    int unsigned   phases_run = 0;
    int unsigned   stall_cycles = 0;

    function automatic int unsigned draw_gap(input logic no_idle);
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // slope of velocity: -floor(w2 * x / 2^24), in Q.28
    function automatic t_acc vel_slope(input t_acc w2, input t_acc x);
        return -((w2 * x) >>> FRAC_SHIFT);
    endfunction

    function automatic t_acc clamp_q428(input t_acc val, output logic hit);
        t_acc top;
        top = (t_acc'(1) <<< (POS_W - 1)) - t_acc'(1);
        hit = 1'b1;
        if (val > top) return top;
        if (val < -top - t_acc'(1)) return -top - t_acc'(1);
        hit = 1'b0;
        return val;
    endfunction

    // One tick: optional reload, one Euler or Heun step, time advance.
    function automatic t_osc_beat advance_oscillator(input logic restart);
        t_acc      dt, w2, x, v, k1, k2, xp, vp, nx, nv;
        logic      hit_x, hit_v, hit_p;
        t_osc_beat res;
        if (restart) begin
            osc_pos  = cfg_x0;
            osc_vel  = cfg_v0;
            osc_time = cfg_t0;
        end
        dt = t_acc'(cfg_dt);    // zero-extended
        w2 = t_acc'(cfg_w2);
        x  = t_acc'(osc_pos);   // sign-extended
        v  = t_acc'(osc_vel);
        k1 = vel_slope(w2, x);
        if (cfg_method == METHOD_HEUN) begin
            // predictor clipping never shows up in the saturated flag
            xp = clamp_q428(x + ((dt * v) >>> FRAC_SHIFT), hit_p);
            vp = clamp_q428(v + ((dt * k1) >>> FRAC_SHIFT), hit_p);
            k2 = vel_slope(w2, xp);
            nx = x + ((dt * v + dt * vp) >>> (FRAC_SHIFT + 1));
            nv = v + ((dt * k1 + dt * k2) >>> (FRAC_SHIFT + 1));
        end else begin
            nx = x + ((dt * v) >>> FRAC_SHIFT);
            nv = v + ((dt * k1) >>> FRAC_SHIFT);
        end
        nx = clamp_q428(nx, hit_x);
        nv = clamp_q428(nv, hit_v);
        osc_pos   = nx[POS_W-1:0];
        osc_vel   = nv[POS_W-1:0];
        res.t_now = osc_time;
        res.pos   = nx[POS_W-1:0];
        res.vel   = nv[POS_W-1:0];
        res.sat   = hit_x | hit_v;
        osc_time  = osc_time + TIME_W'(cfg_dt);   // wraps modulo 2^40
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("MISMATCH beat %0d %s: got %h want %h", results_checked, what, got, want);
    endtask

    // ------------------------------------------------------------- tick driver
    // Slot is free when nothing is offered or the offered beat goes this edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                step_results_q.push_back(advance_oscillator(s_tdata[RESTART_BIT]));
                ticks_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap != 0) begin
                    s_tvalid <= 1'b0;
                    src_gap  <= src_gap - 1;
                end else if (tick_q.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'(tick_q.pop_front()) << RESTART_BIT;
                    src_gap  <= draw_gap(src_no_idle);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------ result monitor
    always @(posedge i_clk) begin
        int unsigned g;
        t_osc_beat   want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            snk_gap  <= 0;
        end else if (m_tvalid && m_tready) begin
            if (step_results_q.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata[63:0], '0);
            end else begin
                want = step_results_q.pop_front();
                if (m_tdata[0 +: TIME_W] !== want.t_now)
                    report_mismatch("time_now", 64'(m_tdata[0 +: TIME_W]), 64'(want.t_now));
                if (m_tdata[TIME_W +: POS_W] !== want.pos)
                    report_mismatch("position", 64'(m_tdata[TIME_W +: POS_W]), 64'(want.pos));
                if (m_tdata[TIME_W + POS_W +: POS_W] !== want.vel)
                    report_mismatch("velocity", 64'(m_tdata[TIME_W + POS_W +: POS_W]),
                                    64'(want.vel));
                if (m_tuser !== want.sat)
                    report_mismatch("saturated", 64'(m_tuser), 64'(want.sat));
                if (want.sat) sat_seen++;
            end
            results_checked++;
            // stall drawn per beat: tready is held low for the drawn gap
            g = draw_gap(snk_no_idle);
            m_tready <= (g == 0);
            snk_gap  <= (g == 0) ? 0 : g - 1;
        end else if (snk_gap != 0) begin
            m_tready <= 1'b0;
            snk_gap  <= snk_gap - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WDOG_LIMIT) begin
            $display("timeout: no beat or register access for %0d cycles", WDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------ register access
    // setup cycle, access cycle; the write lands at the edge with pready high
    task automatic apb_write(input t_reg_idx idx, input logic [APB_DW-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx) << ADDR_LSB;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_METHOD: cfg_method = val[0];
            REG_STEP:   cfg_dt     = val[DT_W-1:0];
            REG_OMEGA2: cfg_w2     = val[W2_W-1:0];
            REG_T0:     cfg_t0     = val[TIME_W-1:0];
            REG_X0:     cfg_x0     = val[POS_W-1:0];
            REG_V0:     cfg_v0     = val[POS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic method, input logic [DT_W-1:0] dt,
                                input logic [W2_W-1:0] w2, input logic [TIME_W-1:0] t0,
                                input logic [POS_W-1:0] x0, input logic [POS_W-1:0] v0);
        apb_write(REG_METHOD, APB_DW'(method));
        apb_write(REG_STEP,   APB_DW'(dt));
        apb_write(REG_OMEGA2, APB_DW'(w2));
        apb_write(REG_T0,     APB_DW'(t0));
        apb_write(REG_X0,     APB_DW'(x0));
        apb_write(REG_V0,     APB_DW'(v0));
    endtask

    // queue n ticks; the first carries first_restart, later ones restart 1 in odds
    task automatic push_ticks(input int n, input logic first_restart, input int odds);
        for (int i = 0; i < n; i++) begin
            if (i == 0) tick_q.push_back(first_restart);
            else tick_q.push_back(odds != 0 && $urandom_range(0, odds - 1) == 0);
            ticks_queued++;
        end
    endtask

    // waits until every queued tick is sent and every predicted beat has come back
    task automatic drain();
        do @(posedge i_clk);
        while (ticks_sent != ticks_queued || step_results_q.size() != 0);
        repeat (4) @(posedge i_clk);
        phases_run++;
    endtask

    task automatic pick_idling();
        src_no_idle = ($urandom_range(0, 3) == 0);
        snk_no_idle = ($urandom_range(0, 3) == 0);
    endtask

    // mostly well-behaved oscillators, sometimes raw full-range values
    task automatic random_setup();
        logic              m;
        logic [DT_W-1:0]   dt;
        logic [W2_W-1:0]   w2;
        logic [TIME_W-1:0] t0;
        logic [POS_W-1:0]  x0, v0;
        m  = 1'($urandom_range(0, 1));
        dt = ($urandom_range(0, 3) == 0) ? DT_W'($urandom) : DT_W'($urandom_range(0, 1 << 18));
        w2 = ($urandom_range(0, 3) == 0) ? W2_W'($urandom) : W2_W'($urandom_range(0, 1 << 28));
        t0 = TIME_W'({$urandom, $urandom});
        x0 = ($urandom_range(0, 3) == 0) ? POS_W'($urandom)
                                         : POS_W'(int'($urandom_range(0, 1 << 30)) - (1 << 29));
        v0 = ($urandom_range(0, 3) == 0) ? POS_W'($urandom)
                                         : POS_W'(int'($urandom_range(0, 1 << 30)) - (1 << 29));
        program_regs(m, dt, w2, t0, x0, v0);
    endtask

    // ------------------------------------------------------------------ sequence
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset state first, without a reload, then a reload of the defaults
        pick_idling();
        push_ticks(2, 1'b0, 0);
        push_ticks(2, 1'b1, 0);
        drain();

        // zero step size: state and time hold still
        program_regs(METHOD_EULER, '0, 32'h0100_0000, 40'd123, 32'h1000_0000, 32'hF800_0000);
        pick_idling();
        push_ticks(2, 1'b1, 0);
        drain();

        // Heun at the extremes: clipped predictor, saturation, time stepping past 2^39
        program_regs(METHOD_HEUN, 24'hFF_FFFF, 32'hFFFF_FFFF, 40'h7F_FFFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF);
        pick_idling();
        push_ticks(3, 1'b1, 0);
        drain();

        // Euler at the opposite extremes, start time at the midpoint of its range
        program_regs(METHOD_EULER, 24'hFF_FFFF, 32'hFFFF_FFFF, 40'h80_0000_0000,
                     32'h7FFF_FFFF, 32'h8000_0000);
        pick_idling();
        push_ticks(3, 1'b1, 0);
        drain();

        // everything zero, start time all ones
        program_regs(METHOD_HEUN, '0, '0, 40'hFF_FFFF_FFFF, '0, '0);
        pick_idling();
        push_ticks(2, 1'b1, 0);
        drain();

        // smallest nonzero step and w2: floor rounding of tiny negative products
        program_regs(METHOD_HEUN, 24'd1, 32'd1, 40'h00_0100_0000, 32'hFFFF_FFFF, 32'd1);
        pick_idling();
        push_ticks(3, 1'b1, 0);
        drain();

        // Euler with the default oscillator
        program_regs(METHOD_EULER, RST_STEP, RST_OMEGA2, RST_T0, RST_X0, RST_V0);
        pick_idling();
        push_ticks(4, 1'b1, 0);
        drain();

        // long random trajectories, fresh settings each phase
        for (int p = 0; p < RAND_PHASES; p++) begin
            random_setup();
            pick_idling();
            push_ticks(RAND_BEATS, 1'($urandom_range(0, 1)), 12);
            drain();
        end

        repeat (SETTLE_CYC) @(posedge i_clk);
        if (step_results_q.size() != 0)
            report_mismatch("beats never delivered", 64'(step_results_q.size()), '0);

        $display("Ran %0d setting phases with Euler and Heun steps, reloads and extremes.",
                 phases_run);
        $display("Ticks sent %0d, beats checked %0d, saturated beats %0d, mismatches %0d.",
                 ticks_sent, results_checked, sat_seen, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
